// ===== rtl/fct_pkg.sv =====
package fct_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int PLANE_W     = 16;
   localparam int FRAC_BITS   = 14;
   localparam int NUM_PLANES  = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 4 * PLANE_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // normal times coordinate, and the widest of product and shifted offset
   localparam int PROD_W  = PLANE_W + COORD_WIDTH;
   localparam int SHIFT_W = PLANE_W + FRAC_BITS;
   localparam int SUM_W   = ((PROD_W > SHIFT_W) ? PROD_W : SHIFT_W) + 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEAR   = 3'd0,
      CSR_FAR    = 3'd1,
      CSR_LEFT   = 3'd2,
      CSR_RIGHT  = 3'd3,
      CSR_TOP    = 3'd4,
      CSR_BOTTOM = 3'd5
   } csr_idx_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [COORD_WIDTH-2:0]        radius_type;

   typedef struct packed {
      logic signed [PLANE_W-1:0] d;
      logic signed [PLANE_W-1:0] nz;
      logic signed [PLANE_W-1:0] ny;
      logic signed [PLANE_W-1:0] nx;
   } plane_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   // one test point per plane, radius is zero for a box
   typedef struct packed {
      point_type [NUM_PLANES-1:0] pt;
      radius_type                 radius;
   } job_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic s1_valid;
      logic advance;
   } back_status_type;

endpackage

// ===== rtl/fct_front.sv =====
module fct_front import fct_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  coord_type                   req_min_x,
   input  coord_type                   req_min_y,
   input  coord_type                   req_min_z,
   input  coord_type                   req_max_x,
   input  coord_type                   req_max_y,
   input  coord_type                   req_max_z,
   input  coord_type                   req_center_x,
   input  coord_type                   req_center_y,
   input  coord_type                   req_center_z,
   input  radius_type                  req_radius,
   input  plane_type [NUM_PLANES-1:0]  planes,
   input  logic                        job_pop,
   output job_type                     job,
   output q_status_type                q_status
);

   job_type                 sel;
   job_type                 queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    full;
   logic                    push;

   // pick the corner furthest along each normal, or the centre for a sphere
   always_comb begin
      for (int i = 0; i < NUM_PLANES; i++) begin
         if (req_command) begin
            sel.pt[i].x = req_center_x;
            sel.pt[i].y = req_center_y;
            sel.pt[i].z = req_center_z;
         end else begin
            sel.pt[i].x = (planes[i].nx > 0) ? req_max_x : req_min_x;
            sel.pt[i].y = (planes[i].ny > 0) ? req_max_y : req_min_y;
            sel.pt[i].z = (planes[i].nz > 0) ? req_max_z : req_min_z;
         end
      end
      sel.radius = req_command ? req_radius : '0;
   end

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign req_stall = full;
   assign push      = req_valid && !full;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = job_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !job_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && job_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= sel;
      end
   end

   assign job            = queue_ff[rd_ptr_ff];
   assign q_status.valid = (count_ff != '0);
   assign q_status.full  = full;

endmodule

// ===== rtl/fct_back.sv =====
module fct_back import fct_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  plane_type [NUM_PLANES-1:0]  planes,
   input  job_type                     job,
   input  q_status_type                q_status,
   output logic                        job_pop,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic                        rsp_visible,
   output back_status_type             b_status
);

   logic                     advance;
   logic                     s1_valid_ff;
   logic                     rsp_valid_ff;
   logic                     visible_ff, visible_in;
   logic signed [PROD_W-1:0] prod_in [NUM_PLANES][3];
   logic signed [PROD_W-1:0] prod_ff [NUM_PLANES][3];
   logic signed [SUM_W-1:0]  bias_in [NUM_PLANES];
   logic signed [SUM_W-1:0]  bias_ff [NUM_PLANES];
   logic signed [SUM_W-1:0]  scaled_sum [NUM_PLANES];
   logic [NUM_PLANES-1:0]    culled;

   // the whole back end moves together whenever the output can take a result
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign job_pop = advance && q_status.valid;

   // stage 1: per plane products, offset and radius folded into one bias
   always_comb begin
      for (int i = 0; i < NUM_PLANES; i++) begin
         prod_in[i][0] = $signed(planes[i].nx) * $signed(job.pt[i].x);
         prod_in[i][1] = $signed(planes[i].ny) * $signed(job.pt[i].y);
         prod_in[i][2] = $signed(planes[i].nz) * $signed(job.pt[i].z);
         bias_in[i]    = (SUM_W'($signed(planes[i].d)) <<< FRAC_BITS)
                       + $signed(SUM_W'(job.radius) << FRAC_BITS);
      end
   end

   // stage 2: scaled distance plus radius must not go negative on any plane
   always_comb begin
      for (int i = 0; i < NUM_PLANES; i++) begin
         scaled_sum[i] = SUM_W'(prod_ff[i][0]) + SUM_W'(prod_ff[i][1])
                       + SUM_W'(prod_ff[i][2]) + bias_ff[i];
         culled[i] = scaled_sum[i][SUM_W-1];
      end
      visible_in = ~|culled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= q_status.valid;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff    <= prod_in;
         bias_ff    <= bias_in;
         visible_ff <= visible_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_visible       = visible_ff;
   assign b_status.s1_valid = s1_valid_ff;
   assign b_status.advance  = advance;

endmodule

// ===== rtl/frustum_cull_test.sv =====
// frustum culling test for boxes and spheres against six planes
//
// csr channel: csr_index selects near, far, left, right, top, bottom (0..5),
// csr_data holds normal x, y, z (Q2.14) and offset, 16 bits each from the
// bottom up. csr_ready is always high; indexes above 5 are dropped.
// Write planes only while no item is in flight.
// req channel: one item per cycle, accepted when req_valid is high and
// req_stall is low. req_command 0 tests the box min/max fields, 1 tests the
// sphere centre and radius.
// rsp channel: each item passes through the queue, the multiply stage and
// the sum stage of the back end before rsp_visible shows its result; one
// result per cycle in steady state while rsp_stall is low.
// while rsp_stall is high with rsp_valid set, the result holds and the back
// end freezes; the two-entry queue behind the front end keeps taking items
// until it is full, then req_stall goes high.
// reset clears all planes to zero, so every shape reads as visible, and
// empties the queue and the pipeline.
module frustum_cull_test import fct_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_command,
   input  coord_type               req_min_x,
   input  coord_type               req_min_y,
   input  coord_type               req_min_z,
   input  coord_type               req_max_x,
   input  coord_type               req_max_y,
   input  coord_type               req_max_z,
   input  coord_type               req_center_x,
   input  coord_type               req_center_y,
   input  coord_type               req_center_z,
   input  radius_type              req_radius,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_visible,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   plane_type [NUM_PLANES-1:0] planes_ff, planes_in;
   job_type                    job;
   q_status_type               q_status;
   back_status_type            b_status;
   logic                       job_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      planes_in = planes_ff;
      if (csr_valid) begin
         unique case (csr_index) inside
            CSR_NEAR, CSR_FAR, CSR_LEFT, CSR_RIGHT, CSR_TOP, CSR_BOTTOM: begin
               planes_in[csr_index] = plane_type'(csr_data);
            end
            default: begin
               planes_in = planes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else begin
         planes_ff <= planes_in;
      end
   end

   fct_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_min_x    (req_min_x),
      .req_min_y    (req_min_y),
      .req_min_z    (req_min_z),
      .req_max_x    (req_max_x),
      .req_max_y    (req_max_y),
      .req_max_z    (req_max_z),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_center_z (req_center_z),
      .req_radius   (req_radius),
      .planes       (planes_ff),
      .job_pop      (job_pop),
      .job          (job),
      .q_status     (q_status)
   );

   fct_back u_back (
      .clock       (clock),
      .reset       (reset),
      .planes      (planes_ff),
      .job         (job),
      .q_status    (q_status),
      .job_pop     (job_pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_visible (rsp_visible),
      .b_status    (b_status)
   );

   // a full queue is never empty
   a_full_has_item: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> q_status.valid)
      else $error("queue full but empty");

   // a popped item lands in the multiply stage
   a_pop_lands: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> b_status.s1_valid)
      else $error("popped item lost");

   // a result only appears behind a valid multiply stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(b_status.s1_valid))
      else $error("result without item");

   // no pop unless the back end moves
   a_pop_advance: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> b_status.advance && q_status.valid)
      else $error("pop while frozen");

endmodule
